@@ hdl/swmh_pkg.sv @@
`timescale 1ns / 1ps

package swmh_pkg;

    localparam int MAX_KEY_LEN = 32;
    localparam int HASH_BITS   = 128;
    localparam int NWORDS      = HASH_BITS / 64;
    localparam int KCNT_W      = $clog2(MAX_KEY_LEN + 1);
    localparam int KIDX_W      = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;

    localparam logic [63:0] P1 = 64'd11400714785074694791;
    localparam logic [63:0] P2 = 64'd14029467366897019727;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
        logic       last;
    } swmh_req_t;

    typedef struct packed {
        logic [63:0] hash_word0;
        logic [63:0] hash_word1;
        logic [1:0]  status;
    } swmh_res_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_KEY_LONG  = 2'd1,
        ST_KEY_ORDER = 2'd2
    } swmh_status_t;

    // operand register source
    typedef enum logic [2:0] {
        T_HOLD,
        T_BYTE,
        T_SALTX,
        T_KEY,
        T_NB0,
        T_NB1,
        T_MIX0,
        T_MIX1
    } swmh_tsel_t;

    // partial-product pass of the 64x64 multiply
    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_LL,
        MUL_HL,
        MUL_LH
    } swmh_mul_t;

    typedef enum logic {
        C_P1,
        C_P2
    } swmh_csel_t;

    // write-back destination
    typedef enum logic [2:0] {
        WB_NONE,
        WB_SALT,
        WB_FOLD,
        WB_W0_NB,
        WB_W1_NB,
        WB_W0_MIX,
        WB_W1_MIX,
        WB_FINISH
    } swmh_wb_t;

    typedef struct packed {
        swmh_tsel_t tsel;
        swmh_mul_t  mul;
        swmh_csel_t csel;
        swmh_wb_t   wb;
    } swmh_ctrl_t;

    typedef struct packed {
        logic last;
        logic fold_done;
    } swmh_flags_t;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
        rotl64 = (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [63:0] sext8(input logic [7:0] b);
        sext8 = {{56{b[7]}}, b};
    endfunction

endpackage

@@ hdl/swmh_mul.sv @@
`timescale 1ns / 1ps

module swmh_mul (
    input  logic                 clk,
    input  swmh_pkg::swmh_mul_t  step,
    input  swmh_pkg::swmh_csel_t csel,
    input  logic [63:0]          a,
    output logic [63:0]          acc
);

    logic [63:0] k;
    logic [31:0] x;
    logic [31:0] y;
    logic [63:0] prod;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;

    // low 64 bits of a*k in three 32x32 passes: lo*lo, then the two cross terms
    assign k    = (csel == swmh_pkg::C_P1) ? swmh_pkg::P1 : swmh_pkg::P2;
    assign x    = (step == swmh_pkg::MUL_HL) ? a[63:32] : a[31:0];
    assign y    = (step == swmh_pkg::MUL_LH) ? k[63:32] : k[31:0];
    assign prod = 64'(x) * 64'(y);

    always_comb
    begin
        unique case (step) inside
            swmh_pkg::MUL_LL:                   acc_next = prod;
            swmh_pkg::MUL_HL, swmh_pkg::MUL_LH: acc_next = acc_reg + {prod[31:0], 32'd0};
            default:                            acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

@@ hdl/swmh_datapath.sv @@
`timescale 1ns / 1ps

module swmh_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  swmh_pkg::swmh_req_t   request,
    input  swmh_pkg::swmh_ctrl_t  ctrl,
    output swmh_pkg::swmh_flags_t flags,
    output swmh_pkg::swmh_res_t   result,
    output logic                  done
);

    logic [7:0]                    key_mem [swmh_pkg::MAX_KEY_LEN];
    logic [7:0]                    key_rd_reg;
    swmh_pkg::swmh_req_t           item_reg;
    logic [63:0]                   salt_reg;
    logic [63:0]                   salt_next;
    logic [63:0]                   t_reg;
    logic [63:0]                   t_next;
    logic [63:0]                   w0_reg;
    logic [63:0]                   w0_next;
    logic [63:0]                   w1_reg;
    logic [63:0]                   w1_next;
    logic [swmh_pkg::KCNT_W-1:0]   key_count_reg;
    logic [swmh_pkg::KCNT_W-1:0]   key_count_next;
    logic [swmh_pkg::KCNT_W-1:0]   idx_reg;
    logic [swmh_pkg::KCNT_W-1:0]   idx_next;
    logic                          in_chal_reg;
    logic                          in_chal_next;
    swmh_pkg::swmh_status_t        err_reg;
    swmh_pkg::swmh_status_t        err_next;
    swmh_pkg::swmh_res_t           res_reg;
    swmh_pkg::swmh_res_t           res_next;
    logic                          done_reg;
    logic                          done_next;
    logic                          key_full;
    logic                          key_wr;
    logic [63:0]                   acc;

    swmh_mul u_mul (
        .clk  (clk),
        .step (ctrl.mul),
        .csel (ctrl.csel),
        .a    (t_reg),
        .acc  (acc)
    );

    assign key_full = (key_count_reg == swmh_pkg::KCNT_W'(swmh_pkg::MAX_KEY_LEN));
    assign key_wr   = accept && !request.op && !key_full;

    always_ff @(posedge clk)
    begin
        if (key_wr)
        begin
            key_mem[key_count_reg[swmh_pkg::KIDX_W-1:0]] <= request.data_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        key_rd_reg <= key_mem[idx_reg[swmh_pkg::KIDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= request;
        end
    end

    always_comb
    begin
        unique case (ctrl.tsel)
            swmh_pkg::T_BYTE:  t_next = swmh_pkg::sext8(item_reg.data_byte);
            swmh_pkg::T_SALTX: t_next = swmh_pkg::rotl64(salt_reg ^ acc, 7);
            swmh_pkg::T_KEY:   t_next = swmh_pkg::sext8(key_rd_reg) + salt_reg;
            swmh_pkg::T_NB0:   t_next = w0_reg ^ (w1_reg >> 3) ^ (w1_reg << 5);
            swmh_pkg::T_NB1:   t_next = w1_reg ^ (w0_reg >> 3) ^ (w0_reg << 5);
            swmh_pkg::T_MIX0:  t_next = w0_reg ^ swmh_pkg::rotl64(w0_reg, 31);
            swmh_pkg::T_MIX1:  t_next = w1_reg ^ swmh_pkg::rotl64(w1_reg, 31);
            default:           t_next = t_reg;
        endcase
    end

    always_comb
    begin
        salt_next      = salt_reg;
        w0_next        = w0_reg;
        w1_next        = w1_reg;
        key_count_next = key_count_reg;
        idx_next       = idx_reg;
        in_chal_next   = in_chal_reg;
        err_next       = err_reg;
        res_next       = res_reg;
        done_next      = 1'b0;

        // bookkeeping on the accepted request; first error wins
        if (accept)
        begin
            if (!request.op)
            begin
                if (err_reg == swmh_pkg::ST_OK)
                begin
                    if (in_chal_reg)
                    begin
                        err_next = swmh_pkg::ST_KEY_ORDER;
                    end
                    else if (key_full)
                    begin
                        err_next = swmh_pkg::ST_KEY_LONG;
                    end
                end
                if (!key_full)
                begin
                    key_count_next = key_count_reg + 1'b1;
                end
            end
            else
            begin
                in_chal_next = 1'b1;
            end
        end

        unique case (ctrl.wb)
            swmh_pkg::WB_SALT:
            begin
                salt_next = acc ^ swmh_pkg::rotl64(acc, 47);
            end
            swmh_pkg::WB_FOLD:
            begin
                if (idx_reg[0])
                begin
                    w1_next = w1_reg ^ acc;
                end
                else
                begin
                    w0_next = w0_reg ^ acc;
                end
                idx_next = idx_reg + 1'b1;
            end
            swmh_pkg::WB_W0_NB:  w0_next = acc ^ swmh_pkg::rotl64(acc, 11);
            swmh_pkg::WB_W1_NB:  w1_next = acc ^ swmh_pkg::rotl64(acc, 11);
            swmh_pkg::WB_W0_MIX: w0_next = acc ^ swmh_pkg::rotl64(acc, 17);
            swmh_pkg::WB_W1_MIX: w1_next = acc ^ swmh_pkg::rotl64(acc, 17);
            swmh_pkg::WB_FINISH:
            begin
                res_next.status = err_reg;
                if (err_reg == swmh_pkg::ST_OK)
                begin
                    res_next.hash_word0 = w0_reg;
                    res_next.hash_word1 = w1_reg;
                end
                else
                begin
                    res_next.hash_word0 = '0;
                    res_next.hash_word1 = '0;
                end
                done_next = 1'b1;
                // drop message state for the next one
                salt_next      = swmh_pkg::P1;
                w0_next        = '0;
                w1_next        = '0;
                key_count_next = '0;
                idx_next       = '0;
                in_chal_next   = 1'b0;
                err_next       = swmh_pkg::ST_OK;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            salt_reg      <= swmh_pkg::P1;
            w0_reg        <= '0;
            w1_reg        <= '0;
            key_count_reg <= '0;
            idx_reg       <= '0;
            in_chal_reg   <= 1'b0;
            err_reg       <= swmh_pkg::ST_OK;
            done_reg      <= 1'b0;
        end
        else
        begin
            salt_reg      <= salt_next;
            w0_reg        <= w0_next;
            w1_reg        <= w1_next;
            key_count_reg <= key_count_next;
            idx_reg       <= idx_next;
            in_chal_reg   <= in_chal_next;
            err_reg       <= err_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg   <= t_next;
        res_reg <= res_next;
    end

    assign flags.last      = item_reg.last;
    assign flags.fold_done = (idx_reg == key_count_reg);
    assign result          = res_reg;
    assign done            = done_reg;

endmodule

@@ hdl/swmh_seq.sv @@
`timescale 1ns / 1ps

module swmh_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  swmh_pkg::swmh_flags_t flags,
    output swmh_pkg::swmh_ctrl_t  ctrl,
    output logic                  busy
);

    localparam int UC_LEN = 36;
    localparam int PC_W   = $clog2(UC_LEN);

    localparam logic [PC_W-1:0] A_FOLD = PC_W'(9);
    localparam logic [PC_W-1:0] A_NB   = PC_W'(15);
    localparam logic [PC_W-1:0] A_ZERO = PC_W'(0);

    typedef enum logic [2:0] {
        J_NEXT,
        J_LAST,
        J_FOLD,
        J_ALWAYS,
        J_END
    } swmh_jmp_t;

    typedef struct packed {
        swmh_pkg::swmh_ctrl_t ctrl;
        swmh_jmp_t            jmp;
        logic [PC_W-1:0]      target;
    } swmh_uword_t;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            run_reg;
    logic            run_next;
    swmh_uword_t     uw;

    function automatic swmh_uword_t mk(
        input swmh_pkg::swmh_tsel_t tsel,
        input swmh_pkg::swmh_mul_t  mul,
        input swmh_pkg::swmh_csel_t csel,
        input swmh_pkg::swmh_wb_t   wb,
        input swmh_jmp_t            jmp,
        input logic [PC_W-1:0]      target
    );
        swmh_uword_t w;
        w.ctrl.tsel = tsel;
        w.ctrl.mul  = mul;
        w.ctrl.csel = csel;
        w.ctrl.wb   = wb;
        w.jmp       = jmp;
        w.target    = target;
        mk = w;
    endfunction

    // microprogram: salt update per byte, then fold, neighbor transform, mix
    always_comb
    begin
        unique case (pc_reg)
            PC_W'(0):  uw = mk(swmh_pkg::T_BYTE,  swmh_pkg::MUL_NONE, swmh_pkg::C_P2,
                               swmh_pkg::WB_NONE, J_NEXT, A_ZERO);
            PC_W'(1):  uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_LL, swmh_pkg::C_P2,
                               swmh_pkg::WB_NONE, J_NEXT, A_ZERO);
            PC_W'(2):  uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_HL, swmh_pkg::C_P2,
                               swmh_pkg::WB_NONE, J_NEXT, A_ZERO);
            PC_W'(3):  uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_LH, swmh_pkg::C_P2,
                               swmh_pkg::WB_NONE, J_NEXT, A_ZERO);
            PC_W'(4):  uw = mk(swmh_pkg::T_SALTX, swmh_pkg::MUL_NONE, swmh_pkg::C_P1,
                               swmh_pkg::WB_NONE, J_NEXT, A_ZERO);
            PC_W'(5):  uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_LL, swmh_pkg::C_P1,
                               swmh_pkg::WB_NONE, J_NEXT, A_ZERO);
            PC_W'(6):  uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_HL, swmh_pkg::C_P1,
                               swmh_pkg::WB_NONE, J_NEXT, A_ZERO);
            PC_W'(7):  uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_LH, swmh_pkg::C_P1,
                               swmh_pkg::WB_NONE, J_NEXT, A_ZERO);
            PC_W'(8):  uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_NONE, swmh_pkg::C_P1,
                               swmh_pkg::WB_SALT, J_LAST, A_ZERO);
            PC_W'(9):  uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_NONE, swmh_pkg::C_P1,
                               swmh_pkg::WB_NONE, J_FOLD, A_NB);
            PC_W'(10): uw = mk(swmh_pkg::T_KEY,   swmh_pkg::MUL_NONE, swmh_pkg::C_P1,
                               swmh_pkg::WB_NONE, J_NEXT, A_ZERO);
            PC_W'(11): uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_LL, swmh_pkg::C_P1,
                               swmh_pkg::WB_NONE, J_NEXT, A_ZERO);
            PC_W'(12): uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_HL, swmh_pkg::C_P1,
                               swmh_pkg::WB_NONE, J_NEXT, A_ZERO);
            PC_W'(13): uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_LH, swmh_pkg::C_P1,
                               swmh_pkg::WB_NONE, J_NEXT, A_ZERO);
            PC_W'(14): uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_NONE, swmh_pkg::C_P1,
                               swmh_pkg::WB_FOLD, J_ALWAYS, A_FOLD);
            PC_W'(15): uw = mk(swmh_pkg::T_NB0,   swmh_pkg::MUL_NONE, swmh_pkg::C_P2,
                               swmh_pkg::WB_NONE, J_NEXT, A_ZERO);
            PC_W'(16): uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_LL, swmh_pkg::C_P2,
                               swmh_pkg::WB_NONE, J_NEXT, A_ZERO);
            PC_W'(17): uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_HL, swmh_pkg::C_P2,
                               swmh_pkg::WB_NONE, J_NEXT, A_ZERO);
            PC_W'(18): uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_LH, swmh_pkg::C_P2,
                               swmh_pkg::WB_NONE, J_NEXT, A_ZERO);
            PC_W'(19): uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_NONE, swmh_pkg::C_P2,
                               swmh_pkg::WB_W0_NB, J_NEXT, A_ZERO);
            PC_W'(20): uw = mk(swmh_pkg::T_NB1,   swmh_pkg::MUL_NONE, swmh_pkg::C_P2,
                               swmh_pkg::WB_NONE, J_NEXT, A_ZERO);
            PC_W'(21): uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_LL, swmh_pkg::C_P2,
                               swmh_pkg::WB_NONE, J_NEXT, A_ZERO);
            PC_W'(22): uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_HL, swmh_pkg::C_P2,
                               swmh_pkg::WB_NONE, J_NEXT, A_ZERO);
            PC_W'(23): uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_LH, swmh_pkg::C_P2,
                               swmh_pkg::WB_NONE, J_NEXT, A_ZERO);
            PC_W'(24): uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_NONE, swmh_pkg::C_P2,
                               swmh_pkg::WB_W1_NB, J_NEXT, A_ZERO);
            PC_W'(25): uw = mk(swmh_pkg::T_MIX0,  swmh_pkg::MUL_NONE, swmh_pkg::C_P1,
                               swmh_pkg::WB_NONE, J_NEXT, A_ZERO);
            PC_W'(26): uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_LL, swmh_pkg::C_P1,
                               swmh_pkg::WB_NONE, J_NEXT, A_ZERO);
            PC_W'(27): uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_HL, swmh_pkg::C_P1,
                               swmh_pkg::WB_NONE, J_NEXT, A_ZERO);
            PC_W'(28): uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_LH, swmh_pkg::C_P1,
                               swmh_pkg::WB_NONE, J_NEXT, A_ZERO);
            PC_W'(29): uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_NONE, swmh_pkg::C_P1,
                               swmh_pkg::WB_W0_MIX, J_NEXT, A_ZERO);
            PC_W'(30): uw = mk(swmh_pkg::T_MIX1,  swmh_pkg::MUL_NONE, swmh_pkg::C_P1,
                               swmh_pkg::WB_NONE, J_NEXT, A_ZERO);
            PC_W'(31): uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_LL, swmh_pkg::C_P1,
                               swmh_pkg::WB_NONE, J_NEXT, A_ZERO);
            PC_W'(32): uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_HL, swmh_pkg::C_P1,
                               swmh_pkg::WB_NONE, J_NEXT, A_ZERO);
            PC_W'(33): uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_LH, swmh_pkg::C_P1,
                               swmh_pkg::WB_NONE, J_NEXT, A_ZERO);
            PC_W'(34): uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_NONE, swmh_pkg::C_P1,
                               swmh_pkg::WB_W1_MIX, J_NEXT, A_ZERO);
            PC_W'(35): uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_NONE, swmh_pkg::C_P1,
                               swmh_pkg::WB_FINISH, J_END, A_ZERO);
            default:   uw = mk(swmh_pkg::T_HOLD,  swmh_pkg::MUL_NONE, swmh_pkg::C_P1,
                               swmh_pkg::WB_NONE, J_END, A_ZERO);
        endcase
    end

    always_comb
    begin
        pc_next  = pc_reg;
        run_next = run_reg;
        if (!run_reg)
        begin
            if (accept)
            begin
                run_next = 1'b1;
                pc_next  = A_ZERO;
            end
        end
        else
        begin
            unique case (uw.jmp)
                J_NEXT:
                begin
                    pc_next = pc_reg + 1'b1;
                end
                J_LAST:
                begin
                    // a byte that is not last ends here
                    if (flags.last)
                    begin
                        pc_next = pc_reg + 1'b1;
                    end
                    else
                    begin
                        run_next = 1'b0;
                        pc_next  = A_ZERO;
                    end
                end
                J_FOLD:
                begin
                    pc_next = flags.fold_done ? uw.target : pc_reg + 1'b1;
                end
                J_ALWAYS:
                begin
                    pc_next = uw.target;
                end
                default:
                begin
                    run_next = 1'b0;
                    pc_next  = A_ZERO;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= A_ZERO;
            run_reg <= 1'b0;
        end
        else
        begin
            pc_reg  <= pc_next;
            run_reg <= run_next;
        end
    end

    always_comb
    begin
        if (run_reg)
        begin
            ctrl = uw.ctrl;
        end
        else
        begin
            ctrl.tsel = swmh_pkg::T_HOLD;
            ctrl.mul  = swmh_pkg::MUL_NONE;
            ctrl.csel = swmh_pkg::C_P1;
            ctrl.wb   = swmh_pkg::WB_NONE;
        end
    end

    assign busy = run_reg;

endmodule

@@ hdl/salted_two_word_mix_hash_unit.sv @@
// Salted two-word mix hash.
// Send a message as key bytes (request.op = 0) followed by challenge bytes
// (request.op = 1), one request per start pulse; a request is taken at a
// rising edge where start is high and busy is low. Mark the final byte with
// request.last. Each byte updates a 64-bit salt; key bytes are also stored.
// After the last byte one result appears on result with done high for exactly
// one cycle: two 64-bit hash words and a status (ok, key too long, key byte
// after challenge byte). On an error both words read zero.
// Timing: every 64-bit multiply runs as three passes through one 32x32
// multiplier under a microcoded sequencer. A byte without last keeps busy
// high until its salt update is written back; no request is taken while busy.
// For a last byte the key fold, neighbor transform and mix follow, and done
// is high in a cycle where busy is already low.
// Reset returns the salt to its start value and clears the key count, the
// error state and the sequencer. After each result the same state is cleared
// for the next message. The receiver cannot stall: done pulses for one cycle.
`timescale 1ns / 1ps

module salted_two_word_mix_hash_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  swmh_pkg::swmh_req_t request,
    output logic                busy,
    output logic                done,
    output swmh_pkg::swmh_res_t result
);

    logic                  accept;
    swmh_pkg::swmh_ctrl_t  ctrl;
    swmh_pkg::swmh_flags_t flags;

    assign accept = start && !busy;

    swmh_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .flags  (flags),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    swmh_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .request (request),
        .ctrl    (ctrl),
        .flags   (flags),
        .result  (result),
        .done    (done)
    );

endmodule

@@ hdl/swmh_checker.sv @@
`timescale 1ns / 1ps

module swmh_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input swmh_pkg::swmh_res_t result
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted request");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == swmh_pkg::ST_OK ||
                  result.status == swmh_pkg::ST_KEY_LONG ||
                  result.status == swmh_pkg::ST_KEY_ORDER))
        else $error("undefined status code");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != swmh_pkg::ST_OK |->
            result.hash_word0 == 64'd0 && result.hash_word1 == 64'd0)
        else $error("hash words not zero on error");

endmodule

bind salted_two_word_mix_hash_unit swmh_checker u_swmh_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import swmh_pkg::*;

    localparam logic OP_KEY       = 1'b0;
    localparam logic OP_CHAL      = 1'b1;
    localparam int   TARGET_BYTES = 400;
    // drain margin covers the result of a message with a full key buffer
    localparam int   DRAIN_CYCLES = 32 + 6 * MAX_KEY_LEN + 40;
    localparam int   CYCLE_LIMIT  = 400000;

    logic      clk     = 1'b0;
    logic      rst_n   = 1'b0;
    logic      start   = 1'b0;
    swmh_req_t request = '0;
    logic      busy;
    logic      done;
    swmh_res_t result;

    swmh_req_t byte_q[$];
    swmh_res_t hash_expect_q[$];
    int        total_bytes = 0;
    int        taken_bytes = 0;
    int        idle_pct    = 0;
    int        mismatches  = 0;
    int        cycles      = 0;

    // shadow copy of the hash state
    logic [63:0]  salt;
    logic [7:0]   key_mem [MAX_KEY_LEN];
    int           key_len;
    logic         seen_chal;
    swmh_status_t err;

    salted_two_word_mix_hash_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [63:0] rot_left(input logic [63:0] x, input int unsigned n);
        return (x << n) | (x >> (64 - n));
    endfunction

    function automatic logic [63:0] sign_ext(input logic [7:0] b);
        return {{56{b[7]}}, b};
    endfunction

    function automatic logic [63:0] final_mix(input logic [63:0] w);
        logic [63:0] v;
        v = w ^ rot_left(w, 31);
        v = v * P1;
        return v ^ rot_left(v, 17);
    endfunction

    task automatic clear_hash_state();
        salt      = P1;
        key_len   = 0;
        seen_chal = 1'b0;
        err       = ST_OK;
    endtask

    // advance the shadow state by one byte; on the last byte queue the hash it yields
    task automatic hash_absorb(input swmh_req_t rq);
        logic [63:0] s;
        logic [63:0] w0;
        logic [63:0] w1;
        swmh_res_t   r;
        s = salt ^ (sign_ext(rq.data_byte) * P2);
        s = rot_left(s, 7);
        s = s * P1;
        salt = s ^ rot_left(s, 47);
        if (rq.op == OP_KEY)
        begin
            if (seen_chal && err == ST_OK)
                err = ST_KEY_ORDER;
            if (key_len < MAX_KEY_LEN)
            begin
                key_mem[key_len] = rq.data_byte;
                key_len++;
            end
            else if (err == ST_OK)
                err = ST_KEY_LONG;
        end
        else
            seen_chal = 1'b1;
        if (rq.last)
        begin
            w0 = '0;
            w1 = '0;
            for (int i = 0; i < key_len; i++)
            begin
                if (i % 2 == 0)
                    w0 ^= (sign_ext(key_mem[i]) + salt) * P1;
                else
                    w1 ^= (sign_ext(key_mem[i]) + salt) * P1;
            end
            // word 1 sees the already transformed word 0
            w0 ^= (w1 >> 3) ^ (w1 << 5);
            w0 = w0 * P2;
            w0 ^= rot_left(w0, 11);
            w1 ^= (w0 >> 3) ^ (w0 << 5);
            w1 = w1 * P2;
            w1 ^= rot_left(w1, 11);
            r.hash_word0 = (err == ST_OK) ? final_mix(w0) : '0;
            r.hash_word1 = (err == ST_OK) ? final_mix(w1) : '0;
            r.status     = err;
            hash_expect_q.push_back(r);
            clear_hash_state();
        end
    endtask

    task automatic push_byte(input logic op, input logic [7:0] data, input logic last);
        swmh_req_t rq;
        rq.op        = op;
        rq.data_byte = data;
        rq.last      = last;
        byte_q.push_back(rq);
    endtask

    // key bytes, then challenge bytes, then key bytes out of order
    task automatic add_message(input int kn, input int cn, input int tn);
        int total;
        if (kn + cn + tn == 0)
            cn = 1;
        total = kn + cn + tn;
        for (int i = 0; i < total; i++)
            push_byte((i < kn || i >= kn + cn) ? OP_KEY : OP_CHAL,
                      8'($urandom_range(255)), i == total - 1);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start   <= 1'b0;
            request <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                hash_absorb(request);
                void'(byte_q.pop_front());
                taken_bytes++;
            end
            if (taken_bytes * 3 < total_bytes)
                idle_pct = 12;
            else if (taken_bytes * 3 < total_bytes * 2)
                idle_pct = 47;
            else
                idle_pct = 0;
            if (byte_q.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                start   <= 1'b1;
                request <= byte_q[0];
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : hash_check
        swmh_res_t want;
        if (rst_n && done)
        begin
            if (hash_expect_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected hash: w0=%h w1=%h status=%0d",
                             result.hash_word0, result.hash_word1, result.status);
            end
            else
            begin
                want = hash_expect_q.pop_front();
                if (result.hash_word0 !== want.hash_word0 ||
                    result.hash_word1 !== want.hash_word1 ||
                    result.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("hash differs: want w0=%h w1=%h status=%0d, got w0=%h w1=%h status=%0d",
                                 want.hash_word0, want.hash_word1, want.status,
                                 result.hash_word0, result.hash_word1, result.status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("salted_two_word_mix_hash_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        int mode;
        int kn;
        int n;
        clear_hash_state();

        // empty key, single challenge byte
        push_byte(OP_CHAL, 8'h00, 1'b1);
        // one key byte, all ones, no challenge
        push_byte(OP_KEY, 8'hFF, 1'b1);
        // sign boundary bytes, odd key length
        push_byte(OP_KEY, 8'h80, 1'b0);
        push_byte(OP_KEY, 8'h7F, 1'b0);
        push_byte(OP_KEY, 8'h00, 1'b0);
        push_byte(OP_CHAL, 8'h01, 1'b0);
        push_byte(OP_CHAL, 8'hFE, 1'b1);
        // key byte after a challenge byte
        push_byte(OP_KEY, 8'h55, 1'b0);
        push_byte(OP_CHAL, 8'hAA, 1'b0);
        push_byte(OP_KEY, 8'h33, 1'b1);
        // overlong key, then an out-of-order key byte: the first error is held
        for (int i = 0; i <= MAX_KEY_LEN; i++)
            push_byte(OP_KEY, 8'(i * 37 + 3), 1'b0);
        push_byte(OP_CHAL, 8'h80, 1'b0);
        push_byte(OP_KEY, 8'h7F, 1'b1);

        while (byte_q.size() < TARGET_BYTES)
        begin
            mode = $urandom_range(99);
            if (mode < 68)
                add_message($urandom_range(0, ($urandom_range(9) == 0) ? MAX_KEY_LEN : 8),
                            $urandom_range(0, 6), 0);
            else if (mode < 80)
                add_message($urandom_range(MAX_KEY_LEN - 1, MAX_KEY_LEN + 4),
                            $urandom_range(0, 3), 0);
            else if (mode < 93)
            begin
                kn = ($urandom_range(3) == 0) ? $urandom_range(MAX_KEY_LEN - 2, MAX_KEY_LEN + 1)
                                              : $urandom_range(0, 6);
                add_message(kn, $urandom_range(1, 4), $urandom_range(1, 4));
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    push_byte(1'($urandom_range(1)), 8'($urandom_range(255)), i == n - 1);
            end
        end
        total_bytes = byte_q.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_q.size() != 0 || hash_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && hash_expect_q.size() == 0)
            $display("salted_two_word_mix_hash_unit: match");
        else
            $display("salted_two_word_mix_hash_unit: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/swmh_pkg.sv
hdl/swmh_mul.sv
hdl/swmh_datapath.sv
hdl/swmh_seq.sv
hdl/salted_two_word_mix_hash_unit.sv
hdl/swmh_checker.sv
test/testbench.sv
